// ===== rtl/c_escape_sequence_decoder_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef C_ESCAPE_SEQUENCE_DECODER_UNIT_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_UNIT_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define CESD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define CESD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cesd_pkg.sv =====
`timescale 1ns / 1ps
package cesd_pkg;

	typedef enum logic [3:0] {
		MODE_PLAIN = 4'b0001,
		MODE_ESC   = 4'b0010,
		MODE_OCT   = 4'b0100,
		MODE_HEX   = 4'b1000
	} mode_t;

	// One decoded byte and its end-of-string flag.
	typedef struct packed {
		logic       last;
		logic [7:0] chr;
	} res_t;

	// Everything the decoder hands back for one request.
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  accum;
		logic [1:0]  num;
		res_t        r1;
		res_t        r0;
	} dec_t;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_X     = 8'h78;

	// Result queue geometry.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	function automatic logic is_oct(input logic [7:0] b);
		is_oct = (b[7:3] == 5'b00110);
	endfunction

	// Bit 4 flags a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] r;
		r = 5'b0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, b[3:0]};
		else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			r = {1'b1, b[3:0] + 4'd9};
		hex_val = r;
	endfunction

endpackage

// ===== rtl/c_escape_sequence_decoder_unit.sv =====
`timescale 1ns / 1ps
// C string escape decoder.
// Slave channel s_*: one raw byte of a string literal body per request, s_tlast
// on the final byte of the string. Master channel m_*: decoded bytes, m_tlast on
// the final decoded byte of each string.
// Each accepted request is decoded in the cycle it is taken and yields zero, one
// or two result bytes, which are written into a four-entry result queue. A
// result is held in the queue and shows on m_* once the results ahead of it are taken.
// Throughput: one request per cycle while the queue has room for two results;
// s_tready is high whenever the queue holds two entries or fewer. A stream whose
// bytes each give one result runs at one byte per cycle in both directions while
// m_tready stays high; a request that gives two results adds two queue entries.
// Escapes open over several requests (backslash, octal run, hex run) produce no
// result until the sequence closes or the final byte flushes it.
// Reset (arst_n low) empties the queue and returns the decoder to plain mode with
// a cleared accumulator. When the receiver stalls, results wait in the queue and
// s_tready drops once fewer than two slots are free.
module c_escape_sequence_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);

	localparam int unsigned QCW = cesd_pkg::QAW + 1;

	cesd_pkg::mode_t mode_q;
	logic [7:0]      accum_q;

	cesd_pkg::res_t                 queue_q [cesd_pkg::QDEPTH];
	logic [cesd_pkg::QAW-1:0]       wr_ptr_q;
	logic [cesd_pkg::QAW-1:0]       rd_ptr_q;
	logic [QCW-1:0]                 count_q;

	cesd_pkg::dec_t dec;
	logic           s_fire;
	logic           m_fire;
	logic [1:0]     push_num;

	// Decode the current byte against the held escape state.
	cesd_decode u_decode (
		.mode_in  (mode_q),
		.accum_in (accum_q),
		.chr_in   (s_tdata),
		.last_in  (s_tlast),
		.dec      (dec)
	);

	// Accept only with room for the worst case of two results.
	assign s_tready = (count_q <= QCW'(cesd_pkg::QDEPTH - 2));
	assign s_fire   = s_tvalid & s_tready;
	assign m_fire   = m_tvalid & m_tready;
	assign push_num = s_fire ? dec.num : 2'd0;

	// Advance the decoder state on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= cesd_pkg::MODE_PLAIN;
			accum_q <= 8'h00;
		end else if (s_fire) begin
			mode_q  <= dec.mode;
			accum_q <= dec.accum;
		end
	end

	// Queue storage: write up to two results at the tail.
	always_ff @(posedge clk) begin
		if (push_num != 2'd0)
			queue_q[wr_ptr_q] <= dec.r0;
		if (push_num == 2'd2)
			queue_q[wr_ptr_q + cesd_pkg::QAW'(1)] <= dec.r1;
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cesd_pkg::QAW'(push_num);
			if (m_fire)
				rd_ptr_q <= rd_ptr_q + cesd_pkg::QAW'(1);
			count_q  <= count_q + QCW'(push_num) - QCW'(m_fire);
		end
	end

	// Head of the queue drives the master channel.
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = queue_q[rd_ptr_q].chr;
	assign m_tlast  = queue_q[rd_ptr_q].last;

endmodule

// ===== rtl/cesd_decode.sv =====
`timescale 1ns / 1ps
module cesd_decode (
	input  cesd_pkg::mode_t mode_in,
	input  logic [7:0]      accum_in,
	input  logic [7:0]      chr_in,
	input  logic            last_in,
	output cesd_pkg::dec_t  dec
);

	always_comb begin
		cesd_pkg::mode_t mode;
		logic [7:0]      acc;
		logic [1:0]      num;
		cesd_pkg::res_t  r0;
		cesd_pkg::res_t  r1;
		logic [4:0]      hv;
		logic            flush;
		logic [7:0]      fchr;

		mode  = mode_in;
		acc   = accum_in;
		num   = 2'd0;
		r0    = '0;
		r1    = '0;
		hv    = cesd_pkg::hex_val(chr_in);
		flush = 1'b0;
		fchr  = 8'h00;

		case (mode_in)
			cesd_pkg::MODE_PLAIN: begin
				if (chr_in == cesd_pkg::CH_BSL) begin
					mode = cesd_pkg::MODE_ESC;
				end else begin
					r0.chr = chr_in;
					num    = 2'd1;
				end
			end
			cesd_pkg::MODE_ESC: begin
				mode = cesd_pkg::MODE_PLAIN;
				num  = 2'd1;
				case (chr_in)
					cesd_pkg::CH_BSL:   r0.chr = cesd_pkg::CH_BSL;
					cesd_pkg::CH_N:     r0.chr = cesd_pkg::CH_LF;
					cesd_pkg::CH_T:     r0.chr = cesd_pkg::CH_TAB;
					cesd_pkg::CH_V:     r0.chr = cesd_pkg::CH_VT;
					cesd_pkg::CH_R:     r0.chr = cesd_pkg::CH_CR;
					cesd_pkg::CH_SQUOT: r0.chr = cesd_pkg::CH_SQUOT;
					cesd_pkg::CH_DQUOT: r0.chr = cesd_pkg::CH_DQUOT;
					cesd_pkg::CH_QMARK: r0.chr = cesd_pkg::CH_QMARK;
					cesd_pkg::CH_X: begin
						acc  = 8'h00;
						mode = cesd_pkg::MODE_HEX;
						num  = 2'd0;
					end
					default: begin
						if (cesd_pkg::is_oct(chr_in)) begin
							acc  = {5'b0, chr_in[2:0]};
							mode = cesd_pkg::MODE_OCT;
							num  = 2'd0;
						end else begin
							// unknown escape: backslash, then the byte as is
							r0.chr = cesd_pkg::CH_BSL;
							r1.chr = chr_in;
							num    = 2'd2;
						end
					end
				endcase
			end
			cesd_pkg::MODE_OCT, cesd_pkg::MODE_HEX: begin
				if (mode_in == cesd_pkg::MODE_OCT && cesd_pkg::is_oct(chr_in)) begin
					acc = {acc[4:0], chr_in[2:0]};
				end else if (mode_in == cesd_pkg::MODE_HEX && hv[4]) begin
					acc = {acc[3:0], hv[3:0]};
				end else begin
					// run ends: emit the value, then treat the byte as plain
					r0.chr = acc;
					acc    = 8'h00;
					if (chr_in == cesd_pkg::CH_BSL) begin
						mode = cesd_pkg::MODE_ESC;
						num  = 2'd1;
					end else begin
						mode   = cesd_pkg::MODE_PLAIN;
						r1.chr = chr_in;
						num    = 2'd2;
					end
				end
			end
			default: mode = cesd_pkg::MODE_PLAIN;
		endcase

		if (last_in) begin
			if (mode == cesd_pkg::MODE_ESC) begin
				flush = 1'b1;
				fchr  = cesd_pkg::CH_BSL;
			end else if (mode == cesd_pkg::MODE_OCT || mode == cesd_pkg::MODE_HEX) begin
				flush = 1'b1;
				fchr  = acc;
			end
			if (flush) begin
				if (num == 2'd0)
					r0.chr = fchr;
				else
					r1.chr = fchr;
				num = num + 2'd1;
			end
			mode = cesd_pkg::MODE_PLAIN;
			acc  = 8'h00;
			if (num == 2'd1)
				r0.last = 1'b1;
			else if (num == 2'd2)
				r1.last = 1'b1;
		end

		dec.mode  = mode;
		dec.accum = acc;
		dec.num   = num;
		dec.r0    = r0;
		dec.r1    = r1;
	end

endmodule

// ===== rtl/cesd_checker.sv =====
`timescale 1ns / 1ps
`include "c_escape_sequence_decoder_unit_assert.svh"
module cesd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// A stalled result keeps its value.
	`CESD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

	// Nothing is offered once reset has been seen at an edge.
	`CESD_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !m_tvalid, "result valid after reset")

	// Back-pressure only comes from a queue that has results to give.
	`CESD_ASSERT(a_stall_has_data, !s_tready |-> m_tvalid, "input stalled with nothing queued")

	// An accepted final byte other than a backslash makes a result visible in the next cycle.
	`CESD_ASSERT(a_last_shows, s_tvalid && s_tready && s_tlast && s_tdata != cesd_pkg::CH_BSL |=> m_tvalid, "final byte produced no result")

endmodule

bind c_escape_sequence_decoder_unit cesd_checker u_cesd_checker (.*);
